>>> src/led_seq_pkg.sv
// ----------------------------------------------------------------------------
// led_seq_pkg
// Shared types and constants for the LED effect sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package led_seq_pkg;

  localparam logic [7:0] FULL_DUTY  = 8'd30;
  localparam logic [7:0] LONG_TICKS = 8'd249;
  localparam logic [7:0] FADE_TICKS = 8'd84;
  localparam logic [7:0] HOLD_STEPS = 8'd49;
  localparam logic [7:0] WAIT_STEPS = 8'd4;

  localparam logic [7:0] BLINK_ON_FIRST   = 8'd1;
  localparam logic [7:0] BLINK_OFF_FIRST  = 8'd2;
  localparam logic [7:0] BLINK_ON_SECOND  = 8'd3;
  localparam logic [7:0] BLINK_OFF_SECOND = 8'd4;
  localparam logic [7:0] BLINK_END        = 8'd5;

  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_WHITE = 3'd1;
  localparam logic [2:0] MODE_RED   = 3'd2;
  localparam logic [2:0] MODE_FADE  = 3'd3;

  localparam logic [1:0] PHASE_TO_WHITE = 2'd0;
  localparam logic [1:0] PHASE_HOLD_W   = 2'd1;
  localparam logic [1:0] PHASE_TO_RED   = 2'd2;
  localparam logic [1:0] PHASE_HOLD_R   = 2'd3;

  typedef struct packed {
    logic [2:0] effect_sel;
    logic       timer_off;
    logic       timer_on;
    logic       flash_request;
  } seq_tick_t;

  typedef struct packed {
    logic [7:0] white_level;
    logic [7:0] red_level;
    logic       flash_busy;
  } seq_level_t;

  typedef struct packed {
    logic       init_done;
    logic [7:0] tick_count;
    logic [7:0] step_count;
    logic [1:0] fade_phase;
    logic [7:0] white_pwm;
    logic [7:0] red_pwm;
    logic       flash_pending;
  } seq_state_t;

endpackage

`default_nettype wire

>>> src/led_effect_sequencer.sv
// ----------------------------------------------------------------------------
// led_effect_sequencer
// Per-tick white/red duty level sequencer with flash, timer-off and crossfade.
// ----------------------------------------------------------------------------
// Each request is one 400 us tick and gives exactly one result carrying the
// white and red duty levels and the flash busy flag after that tick. The block
// takes one request per clock while the request channel is not stalled; a request
// passes an input register, the combinational update logic and a result register,
// moving into the result register whenever the output side is not stalled. A stall
// on the result channel holds the result register and, once the input register
// is also full, stalls the request channel in the same cycle.
`default_nettype none

module led_effect_sequencer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    tick_valid,
  output logic                    tick_stall,
  input  led_seq_pkg::seq_tick_t  tick,
  output logic                    level_valid,
  input  logic                    level_stall,
  output led_seq_pkg::seq_level_t level
);
  import led_seq_pkg::*;

  logic       held_valid;
  seq_tick_t  held;
  seq_state_t state;
  seq_state_t state_next;
  seq_level_t level_next;
  logic       out_free;
  logic       advance;

  assign out_free   = !level_valid || !level_stall;
  assign advance    = held_valid && out_free;
  assign tick_stall = held_valid && !out_free;

  led_seq_step u_step (
    .cur   (state),
    .tick  (held),
    .nxt   (state_next),
    .level (level_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      level_valid <= 1'b0;
      state       <= '0;
    end else begin
      if (!tick_stall) held_valid <= tick_valid;
      if (out_free) level_valid <= held_valid;
      if (advance) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) held <= tick;
    if (advance) level <= level_next;
  end

endmodule

`default_nettype wire

>>> src/led_seq_step.sv
// ----------------------------------------------------------------------------
// led_seq_step
// Next-state and result logic for one tick of the LED effect sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module led_seq_step (
  input  led_seq_pkg::seq_state_t cur,
  input  led_seq_pkg::seq_tick_t  tick,
  output led_seq_pkg::seq_state_t nxt,
  output led_seq_pkg::seq_level_t level
);
  import led_seq_pkg::*;

  always_comb begin
    seq_state_t s;
    s = cur;
    s.flash_pending = cur.flash_pending | tick.flash_request;

    if (s.flash_pending) begin
      if (!s.init_done) begin
        s.init_done  = 1'b1;
        s.white_pwm  = '0;
        s.red_pwm    = '0;
        s.tick_count = '0;
        s.step_count = '0;
      end
      s.tick_count = s.tick_count + 8'd1;
      if (s.tick_count > LONG_TICKS) begin
        s.tick_count = '0;
        s.step_count = s.step_count + 8'd1;
        if (tick.timer_on) begin
          case (s.step_count) inside
            BLINK_ON_FIRST, BLINK_ON_SECOND:   s.white_pwm = FULL_DUTY;
            BLINK_OFF_FIRST, BLINK_OFF_SECOND: s.white_pwm = '0;
            BLINK_END: begin
              s.init_done     = 1'b0;
              s.flash_pending = 1'b0;
            end
            default: ;
          endcase
        end else if (s.step_count > WAIT_STEPS) begin
          s.step_count    = '0;
          s.flash_pending = 1'b0;
          s.init_done     = 1'b0;
        end
      end
    end else if (tick.timer_off) begin
      s.white_pwm = '0;
      s.red_pwm   = '0;
    end else begin
      case (tick.effect_sel)
        MODE_OFF: begin
          s.white_pwm = '0;
          s.red_pwm   = '0;
        end
        MODE_WHITE: begin
          s.white_pwm = FULL_DUTY;
          s.red_pwm   = '0;
        end
        MODE_RED: begin
          s.white_pwm = '0;
          s.red_pwm   = FULL_DUTY;
        end
        MODE_FADE: begin
          if (!s.init_done) begin
            s.init_done  = 1'b1;
            s.white_pwm  = '0;
            s.red_pwm    = FULL_DUTY;
            s.tick_count = '0;
            s.step_count = '0;
            s.fade_phase = PHASE_TO_WHITE;
          end
          // phases chain within one tick, except hold-red back to fade
          if (s.fade_phase == PHASE_TO_WHITE) begin
            s.tick_count = s.tick_count + 8'd1;
            if (s.tick_count > FADE_TICKS) begin
              s.tick_count = '0;
              s.white_pwm  = s.white_pwm + 8'd1;
              s.red_pwm    = s.red_pwm - 8'd1;
              if (s.red_pwm == '0) s.fade_phase = PHASE_HOLD_W;
            end
          end
          if (s.fade_phase == PHASE_HOLD_W) begin
            s.tick_count = s.tick_count + 8'd1;
            if (s.tick_count > LONG_TICKS) begin
              s.tick_count = '0;
              s.step_count = s.step_count + 8'd1;
              if (s.step_count > HOLD_STEPS) begin
                s.step_count = '0;
                s.fade_phase = PHASE_TO_RED;
              end
            end
          end
          if (s.fade_phase == PHASE_TO_RED) begin
            s.tick_count = s.tick_count + 8'd1;
            if (s.tick_count > FADE_TICKS) begin
              s.tick_count = '0;
              s.white_pwm  = s.white_pwm - 8'd1;
              s.red_pwm    = s.red_pwm + 8'd1;
              if (s.white_pwm == '0) s.fade_phase = PHASE_HOLD_R;
            end
          end
          if (s.fade_phase == PHASE_HOLD_R) begin
            s.tick_count = s.tick_count + 8'd1;
            if (s.tick_count > LONG_TICKS) begin
              s.tick_count = '0;
              s.step_count = s.step_count + 8'd1;
              if (s.step_count > HOLD_STEPS) begin
                s.step_count = '0;
                s.fade_phase = PHASE_TO_WHITE;
              end
            end
          end
        end
        default: ;
      endcase
    end

    nxt               = s;
    level.white_level = s.white_pwm;
    level.red_level   = s.red_pwm;
    level.flash_busy  = s.flash_pending;
  end

endmodule

`default_nettype wire

>>> src/led_seq_checker.sv
// ----------------------------------------------------------------------------
// led_seq_checker
// Port-level checks for the LED effect sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module led_seq_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    tick_valid,
  input logic                    tick_stall,
  input led_seq_pkg::seq_tick_t  tick,
  input logic                    level_valid,
  input logic                    level_stall,
  input led_seq_pkg::seq_level_t level
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !level_valid)
    else $error("result valid after reset");

  // request side only backs up when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> level_valid)
    else $error("request stalled with no result waiting");

  // accepted request into an empty output gives a result after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall && !level_valid) |=> ##1 level_valid)
    else $error("result missing two cycles after request");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (level_valid && level_stall) |=> (level_valid && $stable(level)))
    else $error("stalled result changed");

endmodule

bind led_effect_sequencer led_seq_checker u_checker (.*);

`default_nettype wire
